>>> sv/ils_pkg.sv
// ils_pkg: shared constants, codes and types for the indexed list store
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package ils_pkg;

	localparam int CAPACITY    = 64;
	localparam int DATA_W      = 32;
	localparam int OP_W        = 3;
	localparam int POS_W       = 7;
	localparam int ST_W        = 2;
	localparam int CNT_OUT_W   = 7;
	localparam int IDX_W       = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int IN_TDATA_W  = ((OP_W + POS_W + DATA_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((DATA_W + ST_W + CNT_OUT_W + 7) / 8) * 8;
	localparam int GRP_SIZE    = 8;
	localparam int NGRP        = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

	localparam logic [OP_W-1:0] OP_READ   = 3'd0;
	localparam logic [OP_W-1:0] OP_FRONT  = 3'd1;
	localparam logic [OP_W-1:0] OP_BACK   = 3'd2;
	localparam logic [OP_W-1:0] OP_BEFORE = 3'd3;
	localparam logic [OP_W-1:0] OP_DELETE = 3'd4;

	localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
	localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

	typedef logic [DATA_W-1:0] word_t;

	typedef struct packed {
		logic             rd;
		logic             ins;
		logic             del;
		logic [CMP_W-1:0] pos;
		word_t            value;
	} cell_ctrl_t;

endpackage

>>> sv/ils_cell.sv
// ils_cell: one list slot; shifts toward or away from its neighbors on insert/delete
// depends on ils_pkg
`timescale 1ns / 1ps

module ils_cell
	import ils_pkg::*;
(
	input  logic             clk,
	input  cell_ctrl_t       ctrl,
	input  logic [IDX_W-1:0] idx,
	input  word_t            left_data,
	input  word_t            right_data,
	output word_t            entry,
	output word_t            rd_data
);

	word_t            entry_q;
	logic [CMP_W-1:0] idx_w;
	logic             at_pos;
	logic             above;

	assign idx_w  = CMP_W'(idx);
	assign at_pos = (idx_w == ctrl.pos);
	assign above  = (idx_w > ctrl.pos);

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (above) begin
				entry_q <= left_data;
			end else if (at_pos) begin
				entry_q <= ctrl.value;
			end
		end else if (ctrl.del) begin
			if (at_pos || above) begin
				entry_q <= right_data;
			end
		end
	end

	assign entry   = entry_q;
	assign rd_data = (ctrl.rd && at_pos) ? entry_q : '0;

endmodule

>>> sv/ils_gather.sv
// ils_gather: registered two-level or-tree that collects the selected cell word
// depends on ils_pkg
`timescale 1ns / 1ps

module ils_gather
	import ils_pkg::*;
(
	input  logic  clk,
	input  logic  capture,
	input  word_t rd_words [CAPACITY],
	output word_t data
);

	word_t grp_d [NGRP];
	word_t grp_q [NGRP];

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = '0;
		end
		for (int i = 0; i < CAPACITY; i++) begin
			grp_d[i / GRP_SIZE] = grp_d[i / GRP_SIZE] | rd_words[i];
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			grp_q <= grp_d;
		end
	end

	always_comb begin
		data = '0;
		for (int g = 0; g < NGRP; g++) begin
			data = data | grp_q[g];
		end
	end

endmodule

>>> sv/ils_ctrl.sv
// ils_ctrl: request decode, entry count, sequencer and output word register
// depends on ils_pkg
`timescale 1ns / 1ps

module ils_ctrl
	import ils_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output cell_ctrl_t             cell_ctrl,
	input  word_t                  gather_data
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_GATHER
	} state_t;

	state_t                 state_q;
	logic [OP_W-1:0]        op_q;
	logic [POS_W-1:0]       pos_q;
	word_t                  value_q;
	logic [CNT_W-1:0]       count_q;
	logic [ST_W-1:0]        status_q;
	logic                   rd_ok_q;
	logic                   rd_bad_q;
	logic                   m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;

	logic [CMP_W-1:0] cnt_w;
	logic [CMP_W-1:0] pos_w;
	logic [CMP_W-1:0] ins_pos;
	logic             is_ins;
	logic             ins_go;
	logic             del_go;
	logic             rd_ok;
	logic             rd_bad;
	logic [ST_W-1:0]  nxt_status;
	logic [CNT_W-1:0] nxt_count;
	logic             out_load;
	word_t            res_data;

	assign cnt_w = CMP_W'(count_q);
	assign pos_w = CMP_W'(pos_q);

	always_comb begin
		ins_pos    = pos_w;
		is_ins     = 1'b0;
		ins_go     = 1'b0;
		del_go     = 1'b0;
		rd_ok      = 1'b0;
		rd_bad     = 1'b0;
		nxt_status = ST_DONE;
		nxt_count  = count_q;
		unique case (op_q)
			OP_READ: begin
				rd_ok  = (pos_w < cnt_w);
				rd_bad = !(pos_w < cnt_w);
			end
			OP_FRONT: begin
				ins_pos = '0;
				is_ins  = 1'b1;
			end
			OP_BACK: begin
				ins_pos = cnt_w;
				is_ins  = 1'b1;
			end
			OP_BEFORE: begin
				is_ins = 1'b1;
			end
			OP_DELETE: begin
				del_go = (pos_w < cnt_w);
			end
			default: begin
			end
		endcase
		if (is_ins) begin
			priority if (ins_pos > cnt_w) begin
				nxt_status = ST_BADPOS;
			end else if (count_q == CNT_W'(CAPACITY)) begin
				nxt_status = ST_FULL;
			end else begin
				ins_go    = 1'b1;
				nxt_count = count_q + CNT_W'(1);
			end
		end
		if (del_go) begin
			nxt_count = count_q - CNT_W'(1);
		end
		if (rd_bad || (op_q == OP_DELETE && !del_go)) begin
			nxt_status = ST_BADPOS;
		end
	end

	always_comb begin
		cell_ctrl.rd    = (state_q == S_EXEC) && rd_ok;
		cell_ctrl.ins   = (state_q == S_EXEC) && ins_go;
		cell_ctrl.del   = (state_q == S_EXEC) && del_go;
		cell_ctrl.pos   = ins_go ? ins_pos : pos_w;
		cell_ctrl.value = value_q;
	end

	assign out_load = (state_q == S_GATHER) && (!m_valid_q || m_tready);
	assign res_data = rd_ok_q ? gather_data : (rd_bad_q ? '1 : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= '0;
			pos_q     <= '0;
			value_q   <= '0;
			count_q   <= '0;
			status_q  <= ST_DONE;
			rd_ok_q   <= 1'b0;
			rd_bad_q  <= 1'b0;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q    <= s_tdata[OP_W-1:0];
						pos_q   <= s_tdata[OP_W +: POS_W];
						value_q <= s_tdata[OP_W + POS_W +: DATA_W];
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					count_q  <= nxt_count;
					status_q <= nxt_status;
					rd_ok_q  <= rd_ok;
					rd_bad_q <= rd_bad;
					state_q  <= S_GATHER;
				end
				S_GATHER: begin
					if (out_load) begin
						m_data_q  <= OUT_TDATA_W'({CNT_OUT_W'(count_q), status_q, res_data});
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

>>> sv/indexed_list_store_top.sv
// indexed_list_store_top: ordered list of unsigned 32-bit words kept in a row of shifting cells
// depends on ils_pkg, ils_cell, ils_gather, ils_ctrl
//
//   channel  direction  ports                       contents
//   s_*      in         s_tvalid s_tready s_tdata   request word
//   m_*      out        m_tvalid m_tready m_tdata   result word
//
// each request passes through the steps: capture, cell shift / read select, or-tree gather
// the cell row shifts all slots together; the registered or-tree sets the read path
// a finished result waits in the output register while the next request is accepted
// a stalled output holds the sequencer in its gather step until the word is taken
// reset clears the count; slot contents are undefined until written
`timescale 1ns / 1ps

module indexed_list_store_top
	import ils_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // opcode[2:0], position[9:3], value[41:10]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata   // read_data[31:0], status[33:32], entry_count[40:34]
);

	cell_ctrl_t cell_ctrl;
	word_t      gather_data;
	word_t      entry_w [CAPACITY];
	word_t      rd_w    [CAPACITY];

	ils_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cell_ctrl   (cell_ctrl),
		.gather_data (gather_data)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		word_t left_w;
		word_t right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = entry_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = entry_w[i+1];
		end
		ils_cell u_cell (
			.clk        (clk),
			.ctrl       (cell_ctrl),
			.idx        (IDX_W'(i)),
			.left_data  (left_w),
			.right_data (right_w),
			.entry      (entry_w[i]),
			.rd_data    (rd_w[i])
		);
	end

	ils_gather u_gather (
		.clk      (clk),
		.capture  (cell_ctrl.rd),
		.rd_words (rd_w),
		.data     (gather_data)
	);

endmodule

>>> sv/ils_checker.sv
// ils_checker: port-level assertions for indexed_list_store_top, with its bind
// depends on ils_pkg
`timescale 1ns / 1ps

module ils_checker
	import ils_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic [IN_TDATA_W-1:0]  s_tdata,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	logic [ST_W-1:0]      st;
	logic [CNT_OUT_W-1:0] cnt;
	word_t                rdata;

	assign rdata = m_tdata[DATA_W-1:0];
	assign st    = m_tdata[DATA_W +: ST_W];
	assign cnt   = m_tdata[DATA_W + ST_W +: CNT_OUT_W];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> cnt <= CNT_OUT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st == ST_FULL |-> cnt == CNT_OUT_W'(CAPACITY))
		else $error("list full reported below capacity");

	a_bad_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st != ST_DONE |-> rdata == '1 || rdata == '0)
		else $error("failed request carries data");

	a_accept_gap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second word accepted during work");

endmodule

bind indexed_list_store_top ils_checker u_ils_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> tb/sv/testbench.sv
// testbench: self-checking bench for indexed_list_store_top, predicting every result word
// from its own model of the list; depends on ils_pkg and the indexed_list_store_top RTL
`timescale 1ns / 1ps

module testbench;
	import ils_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;
	localparam int PHASE_ITEMS = 465;

	typedef struct {
		word_t                read_data;
		logic [ST_W-1:0]      status;
		logic [CNT_OUT_W-1:0] entry_count;
	} response_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	word_t     list_vals [CAPACITY];
	int        list_len = 0;
	int        fill_target = CAPACITY / 2;
	response_t expected_responses [$];
	int        error_count = 0;
	int        gap_pct = 0;
	int        stall_pct = 0;

	indexed_list_store_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("status: fail");
		$finish;
	end

	// list model
	function automatic logic [ST_W-1:0] place_value(input int pos, input word_t val);
		int i;
		if (pos > list_len)
			return ST_BADPOS;
		if (list_len >= CAPACITY)
			return ST_FULL;
		for (i = list_len; i > pos; i--)
			list_vals[i] = list_vals[i - 1];
		list_vals[pos] = val;
		list_len++;
		return ST_DONE;
	endfunction

	function automatic response_t apply_request(input logic [OP_W-1:0] op,
			input logic [POS_W-1:0] pos, input word_t val);
		response_t r;
		int i;
		r.read_data = '0;
		r.status = ST_DONE;
		case (op)
			OP_READ: begin
				if (int'(pos) < list_len) begin
					r.read_data = list_vals[pos];
				end else begin
					r.read_data = '1;
					r.status = ST_BADPOS;
				end
			end
			OP_FRONT: r.status = place_value(0, val);
			OP_BACK: r.status = place_value(list_len, val);
			OP_BEFORE: r.status = place_value(int'(pos), val);
			OP_DELETE: begin
				if (int'(pos) < list_len) begin
					for (i = int'(pos); i + 1 < list_len; i++)
						list_vals[i] = list_vals[i + 1];
					list_len--;
				end else begin
					r.status = ST_BADPOS;
				end
			end
			default: ;
		endcase
		r.entry_count = list_len[CNT_OUT_W-1:0];
		return r;
	endfunction

	function automatic word_t pick_value();
		case ($urandom_range(19))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '0;
			3: return '1;
			default: return $urandom();
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after the word is taken
	task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
			input word_t val);
		logic [IN_TDATA_W-1:0] word;
		word = '0;
		word[OP_W-1:0] = op;
		word[OP_W +: POS_W] = pos;
		word[OP_W + POS_W +: DATA_W] = val;
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		do @(posedge clk); while (!s_tready);
		expected_responses.push_back(apply_request(op, pos, val));
		@(negedge clk);
	endtask

	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		while (expected_responses.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		response_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_responses.size() == 0) begin
				$error("result word with nothing expected: %h", m_tdata);
				error_count++;
			end else begin
				want = expected_responses.pop_front();
				if (m_tdata[31:0] !== want.read_data) begin
					$error("read_data expected %h actual %h", want.read_data, m_tdata[31:0]);
					error_count++;
				end
				if (m_tdata[33:32] !== want.status) begin
					$error("status expected %0d actual %0d", want.status, m_tdata[33:32]);
					error_count++;
				end
				if (m_tdata[40:34] !== want.entry_count) begin
					$error("entry_count expected %0d actual %0d", want.entry_count,
						m_tdata[40:34]);
					error_count++;
				end
			end
		end
	end

	task automatic test_directed();
		gap_pct = 0;
		stall_pct = 0;
		send_request(OP_READ, 7'd0, 32'h1234_5678);     // read of empty list
		send_request(OP_DELETE, 7'd0, '0);              // delete of empty list
		send_request(OP_BEFORE, 7'd1, 32'h1111_1111);   // insert past the end
		send_request(OP_BEFORE, 7'd0, 32'h7fff_ffff);   // insert at count appends
		send_request(OP_FRONT, 7'd127, 32'h8000_0000);
		send_request(OP_BACK, 7'd0, '0);
		send_request(OP_BACK, 7'd127, '1);
		send_request(OP_BEFORE, 7'd2, 32'h5a5a_a5a5);
		send_request(OP_BEFORE, 7'd5, 32'ha5a5_5a5a);   // insert at count appends
		send_request(OP_READ, 7'd0, '0);
		send_request(OP_READ, 7'd2, '0);
		send_request(OP_READ, 7'd5, '1);
		send_request(OP_READ, 7'd6, '0);                // one past the last entry
		send_request(OP_READ, 7'd127, '0);
		send_request(OP_DELETE, 7'd127, '0);
		send_request(OP_BEFORE, 7'd127, 32'hdead_beef);
		send_request(OP_SPARE_A, 7'd127, '1);
		send_request(OP_SPARE_B, 7'd0, '0);
		send_request(OP_SPARE_C, 7'd64, 32'h0f0f_f0f0);
		send_request(OP_DELETE, 7'd2, '0);
		send_request(OP_DELETE, 7'd0, '0);
		send_request(OP_DELETE, 7'd3, '0);              // last entry
		send_request(OP_READ, 7'd1, '0);
		hold_until_drained();
	endtask

	task automatic test_full_list();
		gap_pct = 10;
		stall_pct = 10;
		while (list_len < CAPACITY) begin
			case ($urandom_range(2))
				0: send_request(OP_FRONT, 7'($urandom_range(127)), pick_value());
				1: send_request(OP_BACK, 7'($urandom_range(127)), pick_value());
				default: send_request(OP_BEFORE, 7'($urandom_range(list_len)), pick_value());
			endcase
		end
		send_request(OP_FRONT, 7'd0, 32'h0bad_0bad);
		send_request(OP_BACK, 7'd0, 32'h0bad_0bad);
		send_request(OP_BEFORE, 7'(CAPACITY), 32'h0bad_0bad);
		send_request(OP_BEFORE, 7'd100, 32'h0bad_0bad);   // bad position wins over full
		send_request(OP_READ, 7'(CAPACITY - 1), '0);
		send_request(OP_READ, 7'(CAPACITY), '0);
		send_request(OP_DELETE, 7'(CAPACITY - 1), '0);
		send_request(OP_BEFORE, 7'(CAPACITY - 1), 32'h7fff_ffff);
		send_request(OP_READ, 7'(CAPACITY - 1), '0);
		hold_until_drained();
	endtask

	task automatic send_random_requests(input int n);
		int k;
		int r;
		logic [OP_W-1:0] op;
		logic [POS_W-1:0] pos;
		for (k = 0; k < n; k++) begin
			if ($urandom_range(31) == 0)
				fill_target = $urandom_range(CAPACITY);
			r = $urandom_range(99);
			pos = ($urandom_range(99) < 85) ? 7'($urandom_range(list_len)) :
				7'($urandom_range(127));
			if (r < 5) begin
				op = 3'($urandom_range(7));
				pos = 7'($urandom_range(127));
			end else if (r < 25) begin
				op = OP_READ;
				if (list_len > 0 && $urandom_range(3) != 0)
					pos = 7'($urandom_range(list_len - 1));
			end else if (list_len < fill_target || (list_len == fill_target &&
					$urandom_range(1) == 0)) begin
				case ($urandom_range(2))
					0: op = OP_FRONT;
					1: op = OP_BACK;
					default: op = OP_BEFORE;
				endcase
			end else begin
				op = OP_DELETE;
				if (list_len > 0 && $urandom_range(7) != 0)
					pos = 7'($urandom_range(list_len - 1));
			end
			send_request(op, pos, pick_value());
		end
	endtask

	task automatic test_random_phases();
		gap_pct = 0;
		stall_pct = 0;
		send_random_requests(PHASE_ITEMS);
		hold_until_drained();
		gap_pct = 75;
		stall_pct = 0;
		send_random_requests(PHASE_ITEMS);
		hold_until_drained();
		gap_pct = 0;
		stall_pct = 75;
		send_random_requests(PHASE_ITEMS);
		hold_until_drained();
		gap_pct = 10;
		stall_pct = 10;
		send_random_requests(PHASE_ITEMS);
		hold_until_drained();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_full_list();
		test_random_phases();
		s_tvalid <= 1'b0;
		while (expected_responses.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
